// File: sv/atc_pkg.sv
package atc_pkg;

    localparam int TIME_BITS = 32;
    localparam int PROG_BITS = 16;

    // played time is clamped to TIME_BITS-1 bits
    localparam int PLAY_W  = TIME_BITS - 1;
    // long division of {played, PROG_BITS zeros} by the loop length
    localparam int DIV_W   = PLAY_W + PROG_BITS;
    localparam int CNT_W   = $clog2(DIV_W + 1);
    localparam int ELAP_W  = 49;
    localparam int PROG_W  = PROG_BITS + 1;
    localparam int DUR_W   = 31;
    localparam int REM_W   = DUR_W + 1;
    localparam int LOOP_W  = 32;

    localparam logic [PROG_W-1:0] ONE_Q     = PROG_W'(1) << PROG_BITS;
    localparam logic [49:0]       ELAP_MAX  = (50'd1 << 47) - 50'd1;
    localparam logic [63:0]       LOOPS_MAX = 64'd2147483647;

    typedef enum logic [3:0] {
        OP_TICK     = 4'd0,
        OP_PLAY     = 4'd1,
        OP_REVERSE  = 4'd2,
        OP_FORWARD  = 4'd3,
        OP_BACKWARD = 4'd4,
        OP_PAUSE    = 4'd5,
        OP_RESUME   = 4'd6,
        OP_STOP     = 4'd7,
        OP_FINISH   = 4'd8,
        OP_CANCEL   = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        RUN_IDLE  = 2'd0,
        RUN_RUN   = 2'd1,
        RUN_PAUSE = 2'd2,
        RUN_STOP  = 2'd3
    } run_t;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_TIME    = 2'd1;
    localparam logic [1:0] KIND_RESTORE = 2'd2;

    localparam logic [1:0] DIR_NORMAL  = 2'd0;
    localparam logic [1:0] DIR_REV     = 2'd1;
    localparam logic [1:0] DIR_ALT     = 2'd2;
    localparam logic [1:0] DIR_ALT_REV = 2'd3;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_FWD  = 2'd1;
    localparam logic [1:0] FILL_BWD  = 2'd2;
    localparam logic [1:0] FILL_BOTH = 2'd3;

    localparam logic [2:0] CFG_DUR    = 3'd0;
    localparam logic [2:0] CFG_DELAY  = 3'd1;
    localparam logic [2:0] CFG_ITER   = 3'd2;
    localparam logic [2:0] CFG_FOREVER = 3'd3;
    localparam logic [2:0] CFG_DIR    = 3'd4;
    localparam logic [2:0] CFG_FILL   = 3'd5;

    // loops still to play after the current one; all ones when endless
    function automatic logic [LOOP_W-1:0] rep_count(input logic forever_i,
                                                    input logic [15:0] iter_i);
        logic [LOOP_W-1:0] r;
        if (forever_i) begin
            r = '1;
        end else if (iter_i == 16'd0) begin
            r = '0;
        end else begin
            r = LOOP_W'(iter_i) - LOOP_W'(1);
        end
        return r;
    endfunction

endpackage

// File: sv/animation_timeline_controller.sv
//  channel   | direction | handshake           | payload
//  s_        | in        | s_valid / s_ready   | s_operation, s_tick_delta
//  m_        | out       | m_valid / m_ready   | m_progress .. m_prepare_event
//  cfg_      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Commands go from accept through S_EXEC to S_DONE. A tick that gets past the
//  delay runs the divider, one radix-2 divider step per cycle over DIV_W = 47
//  quotient bits (loop count, then 16 progress bits). One that ends the run
//  at once (last loop or zero length, as a finish does) skips the divider.
//  s_ready is high only while the sequencer is idle; a word held on m_
//  stalls only the final load. Reset is synchronous, aresetn low.
module animation_timeline_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_operation,
    input  logic [31:0] s_tick_delta,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_progress,
    output logic [1:0]  m_progress_kind,
    output logic        m_reverse_flag,
    output logic [1:0]  m_run_status,
    output logic        m_start_event,
    output logic        m_repeat_event,
    output logic        m_pause_event,
    output logic        m_resume_event,
    output logic        m_stop_event,
    output logic        m_idle_event,
    output logic        m_prepare_event,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_ADD, S_CMP, S_DIV, S_POST, S_NOTE, S_DONE
    } state_t;

    typedef struct packed {
        logic [atc_pkg::PROG_W-1:0] prog;
        logic [1:0]                 kind;
        logic                       ev_start;
        logic                       ev_repeat;
        logic                       ev_pause;
        logic                       ev_resume;
        logic                       ev_stop;
        logic                       ev_idle;
        logic                       ev_prep;
    } res_t;

    state_t state_reg, state_next;
    atc_pkg::op_t op_reg, op_next;
    logic [31:0] delta_reg, delta_next;

    logic [atc_pkg::DUR_W-1:0] dur_reg, dur_next, delay_reg, delay_next;
    logic [15:0] iter_reg, iter_next;
    logic        rf_reg, rf_next;
    logic [1:0]  dm_reg, dm_next, fm_reg, fm_next;

    atc_pkg::run_t run_reg, run_next;
    logic [atc_pkg::ELAP_W-1:0] elap_reg, elap_next;
    logic [atc_pkg::LOOP_W-1:0] loops_reg, loops_next;
    logic rr_reg, rr_next, pb_reg, pb_next, tp_reg, tp_next, dfd_reg, dfd_next;

    logic [atc_pkg::PLAY_W-1:0] played_reg, played_next;
    logic looped_reg, looped_next, stop_reg, stop_next;
    logic [atc_pkg::DIV_W-1:0] dvd_reg, dvd_next, q_reg, q_next;
    logic [atc_pkg::REM_W-1:0] rem_reg, rem_next, mod_reg, mod_next;
    logic [atc_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    res_t res_reg, res_next;
    res_t out_reg, out_next;
    logic out_rr_reg, out_rr_next;
    logic [1:0] out_run_reg, out_run_next;
    logic m_valid_reg, m_valid_next;

    function automatic logic [1:0] init_dir(input logic rr, input logic rf,
                                            input logic [1:0] dm, input logic l0);
        logic nrr;
        logic pb;
        nrr = rr;
        pb  = 1'b0;
        if (!rf) begin
            if (dm == atc_pkg::DIR_REV || dm == atc_pkg::DIR_ALT_REV) begin
                nrr = 1'b1;
            end
            if (dm != atc_pkg::DIR_ALT) begin
                pb = nrr;
            end else begin
                pb = nrr & ~l0;
            end
        end
        return {nrr, pb};
    endfunction

    always_comb begin
        logic en, fhe, alt, do_tog, always_st;
        logic t_rr;
        logic [atc_pkg::LOOP_W-1:0] t_loops;
        logic [1:0] ib;
        logic [49:0] sum;
        logic [atc_pkg::ELAP_W-1:0] diff;
        logic [atc_pkg::PLAY_W-1:0] pl;
        logic [atc_pkg::REM_W-1:0] rem_sh, rem_new;
        logic [atc_pkg::PLAY_W-1:0] q_hi;
        logic [atc_pkg::LOOP_W-1:0] loops_cl;
        logic [atc_pkg::LOOP_W:0] lsub;
        logic [atc_pkg::PROG_W-1:0] v;

        state_next   = state_reg;
        op_next      = op_reg;
        delta_next   = delta_reg;
        dur_next     = dur_reg;
        delay_next   = delay_reg;
        iter_next    = iter_reg;
        rf_next      = rf_reg;
        dm_next      = dm_reg;
        fm_next      = fm_reg;
        run_next     = run_reg;
        elap_next    = elap_reg;
        loops_next   = loops_reg;
        rr_next      = rr_reg;
        pb_next      = pb_reg;
        tp_next      = tp_reg;
        dfd_next     = dfd_reg;
        played_next  = played_reg;
        looped_next  = looped_reg;
        stop_next    = stop_reg;
        dvd_next     = dvd_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        mod_next     = mod_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_rr_next  = out_rr_reg;
        out_run_next = out_run_reg;
        m_valid_next = m_valid_reg;

        en  = rf_reg | (iter_reg != 16'd0);
        fhe = (fm_reg == atc_pkg::FILL_FWD) || (fm_reg == atc_pkg::FILL_BOTH);
        alt = (dm_reg == atc_pkg::DIR_ALT) || (dm_reg == atc_pkg::DIR_ALT_REV);

        do_tog    = 1'b0;
        always_st = 1'b0;
        t_rr      = rr_reg;
        t_loops   = loops_reg;
        ib        = 2'b00;
        sum       = '0;
        diff      = '0;
        pl        = '0;
        rem_sh    = '0;
        rem_new   = '0;
        q_hi      = '0;
        loops_cl  = '0;
        lsub      = '0;
        v         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = atc_pkg::op_t'(s_operation);
                    delta_next  = s_tick_delta;
                    res_next    = '0;
                    looped_next = 1'b0;
                    stop_next   = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                if (op_reg == atc_pkg::OP_TICK) begin
                    if (run_reg == atc_pkg::RUN_RUN) begin
                        state_next = S_ADD;
                    end
                end else if (en) begin
                    case (op_reg)
                        atc_pkg::OP_PLAY, atc_pkg::OP_REVERSE,
                        atc_pkg::OP_FORWARD, atc_pkg::OP_BACKWARD: begin
                            // forward/backward first undo a pending reverse; a
                            // double toggle cancels out, so at most one is done
                            do_tog = (op_reg == atc_pkg::OP_REVERSE)
                                   | ((op_reg == atc_pkg::OP_FORWARD) & rr_reg)
                                   | ((op_reg == atc_pkg::OP_BACKWARD) & ~rr_reg);
                            always_st = (op_reg == atc_pkg::OP_REVERSE)
                                      | (op_reg == atc_pkg::OP_BACKWARD);
                            t_rr = rr_reg ^ do_tog;
                            if (do_tog && (run_reg == atc_pkg::RUN_RUN
                                           || run_reg == atc_pkg::RUN_PAUSE)) begin
                                if (!rf_reg) begin
                                    t_loops = atc_pkg::rep_count(rf_reg, iter_reg)
                                            - loops_reg;
                                end
                                elap_next = atc_pkg::ELAP_W'(dur_reg) - elap_reg;
                            end
                            loops_next = t_loops;
                            rr_next    = t_rr;
                            tp_next    = 1'b0;
                            if (run_reg == atc_pkg::RUN_RUN) begin
                                if (tp_reg ^ do_tog) begin
                                    pb_next = ~pb_reg;
                                end
                                res_next.ev_start = always_st;
                            end else begin
                                ib = init_dir(t_rr, rf_reg, dm_reg, t_loops[0]);
                                res_next.ev_start = 1'b1;
                                run_next = atc_pkg::RUN_RUN;
                                rr_next  = ib[1];
                                pb_next  = ib[0];
                            end
                        end
                        atc_pkg::OP_PAUSE: begin
                            if (run_reg != atc_pkg::RUN_PAUSE) begin
                                if (run_reg == atc_pkg::RUN_IDLE) begin
                                    ib = init_dir(rr_reg, rf_reg, dm_reg, loops_reg[0]);
                                    res_next.ev_start = 1'b1;
                                    tp_next = 1'b0;
                                    rr_next = ib[1];
                                    pb_next = ib[0];
                                end
                                run_next = atc_pkg::RUN_PAUSE;
                                res_next.ev_pause = 1'b1;
                            end
                        end
                        atc_pkg::OP_RESUME: begin
                            if (run_reg != atc_pkg::RUN_RUN) begin
                                run_next = atc_pkg::RUN_RUN;
                                res_next.ev_resume = 1'b1;
                            end
                        end
                        atc_pkg::OP_STOP: begin
                            if (run_reg != atc_pkg::RUN_STOP) begin
                                elap_next  = '0;
                                loops_next = atc_pkg::rep_count(rf_reg, iter_reg);
                                dfd_next   = 1'b0;
                                run_next   = atc_pkg::RUN_STOP;
                                res_next.ev_stop = 1'b1;
                            end
                        end
                        atc_pkg::OP_FINISH: begin
                            if (run_reg != atc_pkg::RUN_STOP) begin
                                loops_next = '0;
                                delta_next = 32'(delay_reg) + 32'(dur_reg);
                                state_next = S_ADD;
                            end
                        end
                        atc_pkg::OP_CANCEL: begin
                            if (run_reg != atc_pkg::RUN_IDLE) begin
                                run_next   = atc_pkg::RUN_IDLE;
                                elap_next  = '0;
                                loops_next = atc_pkg::rep_count(rf_reg, iter_reg);
                                v = fhe ? atc_pkg::ONE_Q : '0;
                                res_next.prog    = pb_reg ? atc_pkg::ONE_Q - v : v;
                                res_next.kind    = atc_pkg::KIND_RESTORE;
                                res_next.ev_prep = 1'b1;
                                res_next.ev_idle = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                // skipped entirely when the elapsed time would overflow
                sum = {{(50 - atc_pkg::ELAP_W){elap_reg[atc_pkg::ELAP_W-1]}}, elap_reg}
                    + 50'(delta_reg);
                if ($signed(sum) > $signed(atc_pkg::ELAP_MAX)) begin
                    state_next = S_DONE;
                end else begin
                    elap_next  = sum[atc_pkg::ELAP_W-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if ($signed(elap_reg) < $signed(atc_pkg::ELAP_W'(delay_reg))) begin
                    if ((fm_reg == atc_pkg::FILL_BWD || fm_reg == atc_pkg::FILL_BOTH)
                        && !dfd_reg) begin
                        res_next.prog = '0;
                        res_next.kind = atc_pkg::KIND_TIME;
                        dfd_next = 1'b1;
                    end
                    state_next = S_DONE;
                end else begin
                    res_next.ev_prep = 1'b1;
                    diff = elap_reg - atc_pkg::ELAP_W'(delay_reg);
                    if (diff > atc_pkg::ELAP_W'({atc_pkg::PLAY_W{1'b1}})) begin
                        pl = '1;
                    end else begin
                        pl = diff[atc_pkg::PLAY_W-1:0];
                    end
                    played_next = pl;
                    dvd_next    = {pl, {atc_pkg::PROG_BITS{1'b0}}};
                    rem_next    = '0;
                    q_next      = '0;
                    cnt_next    = '0;
                    state_next  = S_DIV;
                    if (64'(pl) >= 64'(dur_reg)) begin
                        looped_next = 1'b1;
                        if (dur_reg == '0 && alt && !rf_reg && !iter_reg[0]) begin
                            pb_next = ~pb_reg;
                        end
                        if (loops_reg == '0 || dur_reg == '0) begin
                            loops_next = '0;
                            stop_next  = 1'b1;
                            state_next = S_NOTE;
                        end
                    end
                end
            end
            S_DIV: begin
                rem_sh  = {rem_reg[atc_pkg::REM_W-2:0], dvd_reg[atc_pkg::DIV_W-1]};
                rem_new = rem_sh;
                if (rem_sh >= atc_pkg::REM_W'(dur_reg)) begin
                    rem_new = rem_sh - atc_pkg::REM_W'(dur_reg);
                end
                rem_next = rem_new;
                q_next   = {q_reg[atc_pkg::DIV_W-2:0], rem_sh >= atc_pkg::REM_W'(dur_reg)};
                dvd_next = {dvd_reg[atc_pkg::DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg + atc_pkg::CNT_W'(1);
                // after the integer bits the remainder is played mod duration
                if (cnt_reg + atc_pkg::CNT_W'(1) == atc_pkg::CNT_W'(atc_pkg::PLAY_W)) begin
                    mod_next = rem_new;
                end
                if (cnt_reg + atc_pkg::CNT_W'(1) == atc_pkg::CNT_W'(atc_pkg::DIV_W)) begin
                    state_next = S_POST;
                end
            end
            S_POST: begin
                if (looped_reg) begin
                    q_hi = q_reg[atc_pkg::DIV_W-1:atc_pkg::PROG_BITS];
                    if (64'(q_hi) > atc_pkg::LOOPS_MAX) begin
                        loops_cl = atc_pkg::LOOP_W'(atc_pkg::LOOPS_MAX);
                    end else begin
                        loops_cl = atc_pkg::LOOP_W'(q_hi);
                    end
                    if (!rf_reg) begin
                        lsub = {loops_reg[atc_pkg::LOOP_W-1], loops_reg}
                             - {1'b0, loops_cl};
                        loops_next = lsub[atc_pkg::LOOP_W-1:0];
                        if (lsub[atc_pkg::LOOP_W]) begin
                            stop_next = 1'b1;
                        end
                    end
                    if (alt) begin
                        pb_next = ~pb_reg;
                    end
                    played_next = atc_pkg::PLAY_W'(mod_reg);
                end
                state_next = S_NOTE;
            end
            S_NOTE: begin
                if (stop_reg) begin
                    v = fhe ? atc_pkg::ONE_Q : '0;
                end else begin
                    v = atc_pkg::PROG_W'(q_reg[atc_pkg::PROG_BITS-1:0]);
                end
                res_next.prog      = pb_reg ? atc_pkg::ONE_Q - v : v;
                res_next.ev_repeat = looped_reg & ~stop_reg;
                res_next.kind      = (stop_reg && !fhe) ? atc_pkg::KIND_RESTORE
                                                        : atc_pkg::KIND_TIME;
                if (looped_reg) begin
                    elap_next = atc_pkg::ELAP_W'(played_reg) + atc_pkg::ELAP_W'(delay_reg);
                end
                if (stop_reg && en && run_reg != atc_pkg::RUN_STOP) begin
                    elap_next  = '0;
                    loops_next = atc_pkg::rep_count(rf_reg, iter_reg);
                    dfd_next   = 1'b0;
                    run_next   = atc_pkg::RUN_STOP;
                    res_next.ev_stop = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next = res_reg;
                    if (res_reg.kind == atc_pkg::KIND_NONE) begin
                        out_next.prog = '0;
                    end
                    out_rr_next  = rr_reg;
                    out_run_next = run_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                atc_pkg::CFG_DUR:   dur_next   = cfg_data[atc_pkg::DUR_W-1:0];
                atc_pkg::CFG_DELAY: delay_next = cfg_data[atc_pkg::DUR_W-1:0];
                atc_pkg::CFG_ITER: begin
                    iter_next  = cfg_data[15:0];
                    loops_next = atc_pkg::rep_count(rf_reg, cfg_data[15:0]);
                end
                atc_pkg::CFG_FOREVER: begin
                    rf_next    = cfg_data[0];
                    loops_next = atc_pkg::rep_count(cfg_data[0], iter_reg);
                end
                atc_pkg::CFG_DIR:   dm_next = cfg_data[1:0];
                atc_pkg::CFG_FILL:  fm_next = cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= atc_pkg::OP_TICK;
            delta_reg   <= '0;
            dur_reg     <= '0;
            delay_reg   <= '0;
            iter_reg    <= 16'd1;
            rf_reg      <= 1'b0;
            dm_reg      <= atc_pkg::DIR_NORMAL;
            fm_reg      <= atc_pkg::FILL_FWD;
            run_reg     <= atc_pkg::RUN_IDLE;
            elap_reg    <= '0;
            loops_reg   <= atc_pkg::rep_count(1'b0, 16'd1);
            rr_reg      <= 1'b0;
            pb_reg      <= 1'b0;
            tp_reg      <= 1'b0;
            dfd_reg     <= 1'b0;
            played_reg  <= '0;
            looped_reg  <= 1'b0;
            stop_reg    <= 1'b0;
            dvd_reg     <= '0;
            q_reg       <= '0;
            rem_reg     <= '0;
            mod_reg     <= '0;
            cnt_reg     <= '0;
            res_reg     <= '0;
            out_reg     <= '0;
            out_rr_reg  <= 1'b0;
            out_run_reg <= atc_pkg::RUN_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            delta_reg   <= delta_next;
            dur_reg     <= dur_next;
            delay_reg   <= delay_next;
            iter_reg    <= iter_next;
            rf_reg      <= rf_next;
            dm_reg      <= dm_next;
            fm_reg      <= fm_next;
            run_reg     <= run_next;
            elap_reg    <= elap_next;
            loops_reg   <= loops_next;
            rr_reg      <= rr_next;
            pb_reg      <= pb_next;
            tp_reg      <= tp_next;
            dfd_reg     <= dfd_next;
            played_reg  <= played_next;
            looped_reg  <= looped_next;
            stop_reg    <= stop_next;
            dvd_reg     <= dvd_next;
            q_reg       <= q_next;
            rem_reg     <= rem_next;
            mod_reg     <= mod_next;
            cnt_reg     <= cnt_next;
            res_reg     <= res_next;
            out_reg     <= out_next;
            out_rr_reg  <= out_rr_next;
            out_run_reg <= out_run_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_progress      = out_reg.prog;
    assign m_progress_kind = out_reg.kind;
    assign m_reverse_flag  = out_rr_reg;
    assign m_run_status    = out_run_reg;
    assign m_start_event   = out_reg.ev_start;
    assign m_repeat_event  = out_reg.ev_repeat;
    assign m_pause_event   = out_reg.ev_pause;
    assign m_resume_event  = out_reg.ev_resume;
    assign m_stop_event    = out_reg.ev_stop;
    assign m_idle_event    = out_reg.ev_idle;
    assign m_prepare_event = out_reg.ev_prep;

endmodule

// File: sv/atc_checker.sv
module atc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [16:0] m_progress,
    input logic [1:0]  m_progress_kind,
    input logic [1:0]  m_run_status,
    input logic        m_stop_event,
    input logic        m_idle_event,
    input logic        m_pause_event
);

    // a word with no update carries zero progress
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_progress_kind == atc_pkg::KIND_NONE |-> m_progress == '0)
        else $error("progress set without an update");

    a_idle_ev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_idle_event |-> m_run_status == atc_pkg::RUN_IDLE
                                    && m_progress_kind == atc_pkg::KIND_RESTORE)
        else $error("idle event without idle status");

    a_stop_ev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stop_event |-> m_run_status == atc_pkg::RUN_STOP)
        else $error("stop event without stopped status");

    a_pause_ev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pause_event |-> m_run_status == atc_pkg::RUN_PAUSE)
        else $error("pause event without paused status");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_progress))
        else $error("result word dropped while stalled");

endmodule

bind animation_timeline_controller atc_checker u_atc_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_operation;
    logic [31:0] s_tick_delta;
    logic        m_valid;
    logic        m_ready;
    logic [16:0] m_progress;
    logic [1:0]  m_progress_kind;
    logic        m_reverse_flag;
    logic [1:0]  m_run_status;
    logic        m_start_event;
    logic        m_repeat_event;
    logic        m_pause_event;
    logic        m_resume_event;
    logic        m_stop_event;
    logic        m_idle_event;
    logic        m_prepare_event;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    animation_timeline_controller u_top (.*);

    typedef struct packed {
        logic [16:0] progress;
        logic [1:0]  kind;
        logic        rev;
        logic [1:0]  status;
        logic        ev_start;
        logic        ev_repeat;
        logic        ev_pause;
        logic        ev_resume;
        logic        ev_stop;
        logic        ev_idle;
        logic        ev_prep;
    } frame_t;

    frame_t frame_q[$];
    int     errors;
    int     stall_cycles;
    bit     calm;
    bit     done;

    // shadow of the timeline
    logic [30:0] sh_dur, sh_delay;
    logic [15:0] sh_iter;
    logic        sh_forever;
    logic [1:0]  sh_dir, sh_fill;
    atc_pkg::run_t sh_run;
    longint      sh_elapsed, sh_loops;
    bit          sh_rev, sh_back, sh_toggle, sh_fill_done;
    frame_t      fr;

    localparam longint ONE = 64'd1 << atc_pkg::PROG_BITS;
    localparam longint PMAX = (64'd1 << (atc_pkg::TIME_BITS - 1)) - 1;
    localparam longint EMAX = (64'd1 << 47) - 1;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint loops_reload();
        if (sh_forever) return -1;
        if (sh_iter == 0) return 0;
        return longint'(sh_iter) - 1;
    endfunction

    function automatic bit ends_full();
        return sh_fill == atc_pkg::FILL_FWD || sh_fill == atc_pkg::FILL_BOTH;
    endfunction

    function automatic logic [16:0] flipped(longint v);
        return 17'(sh_back ? ONE - v : v);
    endfunction

    task automatic turn_around();
        sh_rev = !sh_rev;
        sh_toggle = !sh_toggle;
        if (sh_run == atc_pkg::RUN_IDLE || sh_run == atc_pkg::RUN_STOP) return;
        if (!sh_forever) sh_loops = loops_reload() - sh_loops;
        sh_elapsed = longint'(sh_dur) - sh_elapsed;
    endtask

    task automatic kick_off(bit always_ev);
        if (sh_run == atc_pkg::RUN_RUN) begin
            if (sh_toggle) begin
                sh_toggle = 0;
                sh_back = !sh_back;
            end
            if (always_ev) fr.ev_start = 1;
            return;
        end
        sh_toggle = 0;
        fr.ev_start = 1;
        sh_run = atc_pkg::RUN_RUN;
        if (sh_forever) begin
            sh_back = 0;
        end else begin
            if (sh_dir == atc_pkg::DIR_REV || sh_dir == atc_pkg::DIR_ALT_REV) sh_rev = 1;
            if (sh_dir != atc_pkg::DIR_ALT) sh_back = sh_rev;
            else sh_back = sh_rev ? (sh_loops[0] == 1'b0) : 1'b0;
        end
    endtask

    task automatic halt();
        if (sh_run == atc_pkg::RUN_STOP) return;
        sh_elapsed = 0;
        sh_loops = loops_reload();
        sh_fill_done = 0;
        sh_run = atc_pkg::RUN_STOP;
        fr.ev_stop = 1;
    endtask

    task automatic reach_loop(longint played);
        bit     stop_now, looped, alt;
        longint d, n;
        longint v;
        stop_now = 0;
        looped = 0;
        d = longint'(sh_dur);
        if (played >= d) begin
            alt = sh_dir >= atc_pkg::DIR_ALT;
            looped = 1;
            if (d == 0 && alt && !sh_forever && sh_iter[0] == 1'b0) sh_back = !sh_back;
            if (sh_loops == 0 || d == 0) begin
                sh_loops = 0;
                stop_now = 1;
            end else begin
                n = played / d;
                if (n > 64'd2147483647) n = 64'd2147483647;
                played = played % d;
                if (!sh_forever) begin
                    sh_loops -= n;
                    if (sh_loops < 0) stop_now = 1;
                end
                if (alt) sh_back = !sh_back;
            end
            sh_elapsed = played + longint'(sh_delay);
        end
        if (stop_now) v = ends_full() ? ONE : 0;
        else v = (played * ONE) / d;
        fr.progress = flipped(v);
        if (looped && !stop_now) fr.ev_repeat = 1;
        fr.kind = (stop_now && !ends_full()) ? atc_pkg::KIND_RESTORE : atc_pkg::KIND_TIME;
        // stopping needs the commands to be enabled
        if (stop_now && (sh_forever || sh_iter != 0)) halt();
    endtask

    task automatic advance(longint delta);
        longint played;
        if (delta > EMAX - sh_elapsed) return;
        sh_elapsed += delta;
        if (sh_elapsed < longint'(sh_delay)) begin
            if (sh_fill >= atc_pkg::FILL_BWD && !sh_fill_done) begin
                fr.progress = 0;
                fr.kind = atc_pkg::KIND_TIME;
                sh_fill_done = 1;
            end
            return;
        end
        fr.ev_prep = 1;
        played = sh_elapsed - longint'(sh_delay);
        if (played > PMAX) played = PMAX;
        reach_loop(played);
    endtask

    task automatic predict_frame(logic [3:0] op, logic [31:0] delta);
        bit live;
        fr = '0;
        live = sh_forever || sh_iter != 0;
        if (op == atc_pkg::OP_TICK) begin
            if (sh_run == atc_pkg::RUN_RUN) advance(longint'(delta));
        end else if (live) begin
            case (op)
                atc_pkg::OP_PLAY: kick_off(0);
                atc_pkg::OP_REVERSE: begin
                    turn_around();
                    kick_off(1);
                end
                atc_pkg::OP_FORWARD: begin
                    if (sh_rev) turn_around();
                    kick_off(0);
                end
                atc_pkg::OP_BACKWARD: begin
                    if (sh_rev) turn_around();
                    turn_around();
                    kick_off(1);
                end
                atc_pkg::OP_PAUSE: begin
                    if (sh_run != atc_pkg::RUN_PAUSE) begin
                        if (sh_run == atc_pkg::RUN_IDLE) kick_off(0);
                        sh_run = atc_pkg::RUN_PAUSE;
                        fr.ev_pause = 1;
                    end
                end
                atc_pkg::OP_RESUME: begin
                    if (sh_run != atc_pkg::RUN_RUN) begin
                        sh_run = atc_pkg::RUN_RUN;
                        fr.ev_resume = 1;
                    end
                end
                atc_pkg::OP_STOP: halt();
                atc_pkg::OP_FINISH: begin
                    if (sh_run != atc_pkg::RUN_STOP) begin
                        sh_loops = 0;
                        advance(longint'(sh_delay) + longint'(sh_dur));
                    end
                end
                atc_pkg::OP_CANCEL: begin
                    if (sh_run != atc_pkg::RUN_IDLE) begin
                        sh_run = atc_pkg::RUN_IDLE;
                        sh_elapsed = 0;
                        sh_loops = loops_reload();
                        fr.ev_prep = 1;
                        fr.progress = flipped(ends_full() ? ONE : 0);
                        fr.kind = atc_pkg::KIND_RESTORE;
                        fr.ev_idle = 1;
                    end
                end
                default: ;
            endcase
        end
        if (fr.kind == atc_pkg::KIND_NONE) fr.progress = '0;
        fr.rev = sh_rev;
        fr.status = sh_run;
        frame_q.push_back(fr);
    endtask

    task automatic idle_burst();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // valid stays high after the accept; the next call updates or drops it
    task automatic send_op(logic [3:0] op, logic [31:0] delta);
        idle_burst();
        s_valid <= 1'b1;
        s_operation <= op;
        s_tick_delta <= delta;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_frame(op, delta);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // valid stays high after the write; the caller drops it after the last one
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            atc_pkg::CFG_DUR: sh_dur = val[30:0];
            atc_pkg::CFG_DELAY: sh_delay = val[30:0];
            atc_pkg::CFG_ITER: begin
                sh_iter = val[15:0];
                sh_loops = loops_reload();
            end
            atc_pkg::CFG_FOREVER: begin
                sh_forever = val[0];
                sh_loops = loops_reload();
            end
            atc_pkg::CFG_DIR: sh_dir = val[1:0];
            atc_pkg::CFG_FILL: sh_fill = val[1:0];
            default: ;
        endcase
    endtask

    task automatic setup(logic [31:0] dur, logic [31:0] dly, logic [15:0] iter,
                         logic fvr, logic [1:0] dir, logic [1:0] fill);
        drain();
        write_reg(atc_pkg::CFG_DUR, dur);
        write_reg(atc_pkg::CFG_DELAY, dly);
        write_reg(atc_pkg::CFG_ITER, 32'(iter));
        write_reg(atc_pkg::CFG_FOREVER, 32'(fvr));
        write_reg(atc_pkg::CFG_DIR, 32'(dir));
        write_reg(atc_pkg::CFG_FILL, 32'(fill));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        setup(32'd100, 32'd20, 16'd3, 1'b0, atc_pkg::DIR_ALT, atc_pkg::FILL_BOTH);
        send_op(atc_pkg::OP_TICK, 32'd5);
        send_op(atc_pkg::OP_PLAY, 32'hFFFF_FFFF);
        send_op(atc_pkg::OP_TICK, 32'd10);
        send_op(atc_pkg::OP_TICK, 32'd60);
        send_op(atc_pkg::OP_TICK, 32'd250);
        send_op(atc_pkg::OP_REVERSE, 0);
        send_op(atc_pkg::OP_PAUSE, 0);
        send_op(atc_pkg::OP_PAUSE, 0);
        send_op(atc_pkg::OP_RESUME, 0);
        send_op(atc_pkg::OP_FORWARD, 0);
        send_op(atc_pkg::OP_BACKWARD, 0);
        send_op(atc_pkg::OP_TICK, 32'hFFFF_FFFF);
        send_op(atc_pkg::OP_FINISH, 0);
        send_op(atc_pkg::OP_STOP, 0);
        send_op(atc_pkg::OP_CANCEL, 0);
        send_op(4'd12, 32'd7);
        send_op(4'd15, 0);
        setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, atc_pkg::DIR_ALT_REV,
              atc_pkg::FILL_NONE);
        send_op(atc_pkg::OP_PLAY, 0);
        send_op(atc_pkg::OP_TICK, 32'hFFFF_FFFF);
        send_op(atc_pkg::OP_TICK, 32'hFFFF_FFFF);
        send_op(atc_pkg::OP_FINISH, 0);
        setup(32'd0, 32'd0, 16'd0, 1'b0, atc_pkg::DIR_NORMAL, atc_pkg::FILL_FWD);
        send_op(atc_pkg::OP_PLAY, 0);
        send_op(atc_pkg::OP_CANCEL, 0);
        drain();
        write_reg(atc_pkg::CFG_ITER, 32'd2);
        write_reg(3'd7, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_op(atc_pkg::OP_PLAY, 0);
        send_op(atc_pkg::OP_TICK, 32'd1);
    endtask

    task automatic test_random(int n_items);
        int          k;
        int          r;
        logic [3:0]  op;
        logic [31:0] delta;
        for (k = 0; k < n_items; k++) begin
            if (k % 150 == 0) begin
                setup($urandom_range(0, 5) == 0 ? $urandom() : $urandom_range(0, 400),
                      $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 200),
                      $urandom_range(0, 9) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 5)),
                      $urandom_range(0, 4) == 0, 2'($urandom()), 2'($urandom()));
            end
            if (k > n_items - 200) calm = 1;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                op = atc_pkg::OP_TICK;
                delta = (r < 3) ? $urandom() : $urandom_range(0, 150);
            end else if (r < 95) begin
                op = 4'($urandom_range(1, 9));
                delta = $urandom();
            end else begin
                op = 4'($urandom());
                delta = $urandom();
            end
            send_op(op, delta);
        end
    endtask

    task automatic check_field(string name, longint want_v, longint got_v);
        if (got_v !== want_v) begin
            $error("%s exp %0d got %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    // result side: random back-pressure, then compare against the oldest prediction
    always @(posedge aclk) begin
        frame_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_q.size() == 0) begin
                    $error("unexpected result word");
                    errors++;
                end else begin
                    want = frame_q.pop_front();
                    check_field("progress", want.progress, m_progress);
                    check_field("progress_kind", want.kind, m_progress_kind);
                    check_field("reverse_flag", want.rev, m_reverse_flag);
                    check_field("run_status", want.status, m_run_status);
                    check_field("start_event", want.ev_start, m_start_event);
                    check_field("repeat_event", want.ev_repeat, m_repeat_event);
                    check_field("pause_event", want.ev_pause, m_pause_event);
                    check_field("resume_event", want.ev_resume, m_resume_event);
                    check_field("stop_event", want.ev_stop, m_stop_event);
                    check_field("idle_event", want.ev_idle, m_idle_event);
                    check_field("prepare_event", want.ev_prep, m_prepare_event);
                end
            end
            if (stall_cycles > 0) begin
                stall_cycles <= stall_cycles - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_cycles <= $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on accepted words of any channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= 5000 && !done) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        calm = 0;
        done = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = '0;
        s_tick_delta = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sh_dur = 0;
        sh_delay = 0;
        sh_iter = 1;
        sh_forever = 0;
        sh_dir = atc_pkg::DIR_NORMAL;
        sh_fill = atc_pkg::FILL_FWD;
        sh_run = atc_pkg::RUN_IDLE;
        sh_elapsed = 0;
        sh_loops = 0;
        sh_rev = 0;
        sh_back = 0;
        sh_toggle = 0;
        sh_fill_done = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(1900);
        drain();
        done = 1;
        if (errors == 0 && frame_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
